// ===== hw/rtl/hashed_message_dedup_filter_defines.svh =====
// Assertion helpers for the dedup filter checker.
`ifndef HASHED_MESSAGE_DEDUP_FILTER_DEFINES_SVH
`define HASHED_MESSAGE_DEDUP_FILTER_DEFINES_SVH

// same-cycle implication, held off during reset
`define HMDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define HMDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hmdf_pkg.sv =====
`default_nettype none
package hmdf_pkg;

  // FNV-1a 64-bit constants; prime is 2^40 + 0x1b3
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  // table depth, a power of two: the slot is the low bits of the hash
  localparam int TABLE_SLOTS_DEF = 2048;

  // jobs in flight between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        duplicate;
    logic [63:0] message_hash;
  } out_word_t;

  typedef struct packed {
    logic [63:0] hash;
    logic        dedup_en;
  } job_t;

  typedef struct packed {
    logic queue_full;
    logic table_clearing;
  } front_status_t;

  // one FNV-1a round: xor the byte in, multiply by the prime as shift-adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hmdf_front.sv =====
`default_nettype none
module hmdf_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  hmdf_pkg::in_word_t     in_data,
  input  logic                   cfg_wen,
  input  logic                   cfg_wdata,
  input  hmdf_pkg::front_status_t status,
  output logic                   push,
  output hmdf_pkg::job_t         push_job
);

  logic [63:0] running_hash;
  logic [63:0] hash_next;
  logic        dedup_enable;
  logic        accept;

  assign in_stall  = status.queue_full || status.table_clearing;
  assign accept    = in_valid && !in_stall;
  assign hash_next = hmdf_pkg::fnv_step(running_hash, in_data.data_byte);

  assign push              = accept && in_data.last_byte;
  assign push_job.hash     = hash_next;
  assign push_job.dedup_en = dedup_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= hmdf_pkg::FNV_BASIS;
      dedup_enable <= 1'b0;
    end else begin
      if (cfg_wen) begin
        dedup_enable <= cfg_wdata;
      end
      if (accept) begin
        running_hash <= in_data.last_byte ? hmdf_pkg::FNV_BASIS : hash_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hmdf_queue.sv =====
`default_nettype none
module hmdf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hmdf_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           nonempty,
  output hmdf_pkg::job_t head
);

  localparam int PTR_W = $clog2(hmdf_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(hmdf_pkg::QUEUE_DEPTH + 1);

  hmdf_pkg::job_t slots [hmdf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(hmdf_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(hmdf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(hmdf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hmdf_back.sv =====
`default_nettype none
module hmdf_back #(
  parameter int TABLE_SLOTS = hmdf_pkg::TABLE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  hmdf_pkg::job_t      job,
  output logic                pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_stall,
  output hmdf_pkg::out_word_t out_data
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);

  logic [63:0]       seen [TABLE_SLOTS];
  logic [SLOT_W-1:0] clr_addr;
  logic [63:0]       rd_data;

  // lookup stage: job whose table word is in rd_data
  logic              s1_valid;
  hmdf_pkg::job_t    s1_job;
  logic              s1_byp;
  logic [63:0]       byp_hash;

  logic              s1_go;
  logic              s1_dup;
  logic              s1_wr;
  logic [63:0]       match_data;
  logic [SLOT_W-1:0] s1_slot;
  logic [SLOT_W-1:0] head_slot;

  assign s1_slot    = s1_job.hash[SLOT_W-1:0];
  assign head_slot  = job.hash[SLOT_W-1:0];
  assign s1_go      = s1_valid && (!out_valid || !out_stall);
  // previous job wrote this slot on the edge that read it
  assign match_data = s1_byp ? byp_hash : rd_data;
  assign s1_dup     = s1_job.dedup_en && (match_data == s1_job.hash);
  assign s1_wr      = s1_go && s1_job.dedup_en && !s1_dup;
  assign pop        = job_valid && !clearing && (!s1_valid || s1_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == SLOT_W'(TABLE_SLOTS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_job   <= job;
      s1_byp   <= s1_wr && (s1_slot == head_slot);
      byp_hash <= s1_job.hash;
    end
    if (s1_go) begin
      out_data.duplicate    <= s1_dup;
      out_data.message_hash <= s1_job.hash;
    end
  end

  // table: one write port (clear or update), one registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      seen[clr_addr] <= '0;
    end else if (s1_wr) begin
      seen[s1_slot] <= s1_job.hash;
    end
    if (pop) begin
      rd_data <= seen[head_slot];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hashed_message_dedup_filter.sv =====
// channel  dir  handshake           word
// in       in   in_valid/in_stall   in_data  : data_byte, last_byte
// out      out  out_valid/out_stall out_data : duplicate, message_hash
// cfg      in   cfg_wen             cfg_wdata: dedup_enable
//
// One byte is taken every cycle while in_stall is low; the hash round (xor,
// then shift-add by the FNV prime) is combinational in the front.
// A result passes the queue, then the table read and compare, then the output
// register. Back-to-back one-byte messages sustain one result a cycle while
// out_stall is low. Reset is synchronous; afterwards the table is swept to
// zero, one slot a cycle through every slot, with in_stall high throughout.
// out_stall holds the output register; up to QUEUE_DEPTH messages plus the
// one in lookup buffer behind it before in_stall rises.
`default_nettype none
module hashed_message_dedup_filter #(
  parameter int TABLE_SLOTS = hmdf_pkg::TABLE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hmdf_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hmdf_pkg::out_word_t out_data,
  input  logic                cfg_wen,
  input  logic                cfg_wdata
);

  hmdf_pkg::front_status_t status;
  hmdf_pkg::job_t          push_job;
  hmdf_pkg::job_t          head;
  logic                    push;
  logic                    pop;
  logic                    q_full;
  logic                    q_nonempty;
  logic                    clearing;

  assign status.queue_full     = q_full;
  assign status.table_clearing = clearing;

  // front: hash fold, dedup_enable register, message hand-off
  hmdf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .status   (status),
    .push     (push),
    .push_job (push_job)
  );

  // finished hashes waiting for the table
  hmdf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .full    (q_full),
    .nonempty(q_nonempty),
    .head    (head)
  );

  // back: table lookup, update with same-slot bypass, output register
  hmdf_back #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(q_nonempty),
    .job      (head),
    .pop      (pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/hmdf_checker.sv =====
`default_nettype none
`include "hashed_message_dedup_filter_defines.svh"
module hmdf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input hmdf_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input hmdf_pkg::out_word_t out_data,
  input logic                cfg_wen,
  input logic                cfg_wdata
);

  logic en_shadow;
  logic rst_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      en_shadow <= 1'b0;
      rst_q     <= 1'b1;
    end else begin
      rst_q <= 1'b0;
      if (cfg_wen) begin
        en_shadow <= cfg_wdata;
      end
    end
  end

  `HMDF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  `HMDF_ASSERT_NOW(a_no_dup_disabled, clk, rst, out_valid && !en_shadow, !out_data.duplicate, "duplicate flagged with dedup off")

  `HMDF_ASSERT_NOW(a_clear_after_reset, clk, rst, rst_q, in_stall && !out_valid, "input taken during table clear")

  `HMDF_ASSERT_NOW(a_accept_known, clk, rst, in_valid && !in_stall, !$isunknown(in_data.last_byte), "accepted word with unknown last mark")

endmodule

bind hashed_message_dedup_filter hmdf_checker u_checker (.*);
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Table geometry follows the default the DUT is built with.
  localparam int          NUM_SLOTS     = hmdf_pkg::TABLE_SLOTS_DEF;
  localparam int          SLOT_BITS     = $clog2(NUM_SLOTS);
  localparam logic [63:0] FNV_MULT      = 64'h0000_0100_0000_01b3;
  localparam int          MAX_LEN       = 24;
  localparam int          POOL_SIZE     = 32;
  localparam int          MAX_GAP       = 12;
  // allow for the result's pass through queue, lookup and output register, and for the job queue to empty
  localparam int          SETTLE_CYCLES = hmdf_pkg::QUEUE_DEPTH + 6;
  localparam int          RANDOM_BYTES  = 1300;
  localparam int          PHASE_BYTES   = 220;
  // covers the slowest run, sweep after reset included
  localparam int          CYCLE_LIMIT   = 400000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  hmdf_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  hmdf_pkg::out_word_t out_data;
  logic                cfg_wen;
  logic                cfg_wdata;

  hashed_message_dedup_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Hash/dedup predictor: own copy of the running hash, the slot table and the
  // enable bit. Updated at the edge where a word is taken.
  // ---------------------------------------------------------------------------
  logic [63:0]         pred_running;
  logic [63:0]         pred_seen [NUM_SLOTS];
  logic                pred_dedup_on;
  hmdf_pkg::out_word_t verdict_q [$];   // expected verdicts, oldest first

  int errors;
  int cycle_count;

  // idle-free stretches on either side
  bit                  in_quiet;
  bit                  out_quiet;
  int                  out_hold;
  hmdf_pkg::out_word_t want_word;

  // message being sent
  logic [7:0] msg_buf [MAX_LEN];
  int         msg_len;

  // recent messages, replayed to provoke duplicates
  logic [7:0] pool_bytes [POOL_SIZE][MAX_LEN];
  int         pool_len   [POOL_SIZE];
  int         pool_fill;
  int         pool_next;

  // colliding pair found by the collision test, reused by the toggle test
  int col_a;
  int col_b;

  // one FNV-1a round, written as a plain multiply mod 2^64
  function automatic logic [63:0] fnv_fold(logic [63:0] h, logic [7:0] b);
    return (h ^ {56'd0, b}) * FNV_MULT;
  endfunction

  function automatic void absorb_word(hmdf_pkg::in_word_t w);
    logic [63:0]         h;
    hmdf_pkg::out_word_t v;
    h = fnv_fold(pred_running, w.data_byte);
    if (!w.last_byte) begin
      pred_running = h;
      return;
    end
    pred_running   = hmdf_pkg::FNV_BASIS;
    v.duplicate    = 1'b0;
    v.message_hash = h;
    if (pred_dedup_on) begin
      if (pred_seen[h[SLOT_BITS-1:0]] == h) begin
        v.duplicate = 1'b1;
      end else begin
        // collision or first sight: the slot simply takes the new hash
        pred_seen[h[SLOT_BITS-1:0]] = h;
      end
    end
    verdict_q = {verdict_q, v};
  endfunction

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Gap is drawn up front; valid is only lowered when a gap is taken, so a
  // back-to-back word never sees valid dropped and raised in one step.
  task automatic send_word(logic [7:0] b, logic last);
    int                 gap;
    hmdf_pkg::in_word_t w;
    gap         = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
    w.data_byte = b;
    w.last_byte = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    absorb_word(w);
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg_len; i++) begin
      send_word(msg_buf[i], i == msg_len - 1);
    end
  endtask

  // Message number n: 0..255 is the single byte n, above that two bytes.
  task automatic load_numbered(int n);
    if (n < 256) begin
      msg_len    = 1;
      msg_buf[0] = n[7:0];
    end else begin
      msg_len    = 2;
      msg_buf[0] = 8'((n - 256) >> 8);
      msg_buf[1] = 8'(n - 256);
    end
  endtask

  // Hold off until every verdict is in, then let the pipe settle.
  task automatic pause_for_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only ever called at a message boundary with the block drained.
  task automatic set_dedup(logic v);
    pause_for_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen       <= 1'b0;
    pred_dedup_on  = v;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: takes a word, checks it against the oldest verdict, then
  // draws how long to hold stall before the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        note_mismatch("result with nothing expected", out_data.message_hash, 64'd0);
      end else begin
        want_word = verdict_q.pop_front();
        if (out_data.duplicate !== want_word.duplicate) begin
          note_mismatch("duplicate", 64'(out_data.duplicate), 64'(want_word.duplicate));
        end
        if (out_data.message_hash !== want_word.message_hash) begin
          note_mismatch("message_hash", out_data.message_hash, want_word.message_hash);
        end
      end
      out_hold = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
    end else if (out_hold > 0) begin
      out_hold--;
    end
    out_stall <= (out_hold > 0);
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset dedup is off: a repeat is still delivered. Bytes 00 and ff,
  // last mark both ways.
  task automatic check_disabled_passthrough();
    msg_len    = 2;
    msg_buf[0] = 8'h00;
    msg_buf[1] = 8'hff;
    send_msg();
    send_msg();
  endtask

  // With dedup on the second copy is dropped; the first pass above left the
  // table untouched, so the first copy here is new.
  task automatic check_repeat_dropped();
    set_dedup(1'b1);
    msg_len    = 2;
    msg_buf[0] = 8'h00;
    msg_buf[1] = 8'hff;
    send_msg();
    send_msg();
  endtask

  // Two messages sharing a slot: B evicts A, so A is new again, then a repeat.
  task automatic check_slot_collision();
    int          owner [int];
    logic [63:0] h;
    int          s;
    col_a = -1;
    col_b = -1;
    for (int n = 0; n < 256 + 65536 && col_b < 0; n++) begin
      load_numbered(n);
      h = hmdf_pkg::FNV_BASIS;
      for (int i = 0; i < msg_len; i++) h = fnv_fold(h, msg_buf[i]);
      s = int'(h[SLOT_BITS-1:0]);
      if (owner.exists(s)) begin
        col_a = owner[s];
        col_b = n;
      end else begin
        owner[s] = n;
      end
    end
    load_numbered(col_a);
    send_msg();
    load_numbered(col_b);
    send_msg();
    load_numbered(col_a);
    send_msg();
    send_msg();
  endtask

  // Switching dedup off leaves the table alone and stops writes to it; on
  // again, A (stored above) is still there despite B passing in between.
  task automatic check_toggle_keeps_table();
    set_dedup(1'b0);
    load_numbered(col_a);
    send_msg();
    load_numbered(col_b);
    send_msg();
    set_dedup(1'b1);
    load_numbered(col_a);
    send_msg();
  endtask

  // Published zero-hash input for FNV-1a 64: slot 0 starts at zero, so such
  // a hash counts as seen on first sight.
  task automatic check_zero_hash();
    msg_len    = 8;
    msg_buf[0] = 8'hd5;
    msg_buf[1] = 8'h6b;
    msg_buf[2] = 8'hb9;
    msg_buf[3] = 8'h53;
    msg_buf[4] = 8'h42;
    msg_buf[5] = 8'h87;
    msg_buf[6] = 8'h08;
    msg_buf[7] = 8'h36;
    send_msg();
  endtask

  // Mixed traffic in phases, dedup setting changed between phases with the
  // block drained. Replays and one-bit mutants of recent messages keep the
  // duplicate and near-miss paths busy.
  task automatic check_random_traffic();
    int sent;
    int next_switch;
    int phase;
    int r;
    int pick;
    int k;
    int msgs;
    bit replay;
    sent        = 0;
    next_switch = PHASE_BYTES;
    phase       = 0;
    msgs        = 0;
    pool_fill   = 0;
    pool_next   = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent >= next_switch) begin
        phase++;
        next_switch += PHASE_BYTES;
        if (phase == 1) begin
          set_dedup(1'b0);
        end else if (phase == 2) begin
          set_dedup(1'b1);
        end else begin
          set_dedup(1'($urandom_range(0, 1)));
        end
      end
      if (msgs % 40 == 0) begin
        in_quiet  = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
      end
      r      = $urandom_range(0, 99);
      replay = (pool_fill > 0 && r < 35);
      if (pool_fill > 0 && r < 45) begin
        pick    = $urandom_range(0, pool_fill - 1);
        msg_len = pool_len[pick];
        for (int i = 0; i < msg_len; i++) msg_buf[i] = pool_bytes[pick][i];
        if (!replay) begin
          k          = $urandom_range(0, msg_len - 1);
          msg_buf[k] = msg_buf[k] ^ 8'(1 << $urandom_range(0, 7));
        end
      end else begin
        msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, MAX_LEN)
                                              : $urandom_range(1, 6);
        for (int i = 0; i < msg_len; i++) msg_buf[i] = 8'($urandom_range(0, 255));
      end
      if (!replay) begin
        pool_len[pool_next] = msg_len;
        for (int i = 0; i < msg_len; i++) pool_bytes[pool_next][i] = msg_buf[i];
        pool_next = (pool_next + 1) % POOL_SIZE;
        if (pool_fill < POOL_SIZE) pool_fill++;
      end
      send_msg();
      sent += msg_len;
      msgs++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog, sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    errors        = 0;
    out_hold      = 0;
    in_quiet      = 1'b0;
    out_quiet     = 1'b0;
    pred_running  = hmdf_pkg::FNV_BASIS;
    pred_dedup_on = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) pred_seen[i] = 64'd0;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // the table sweep after reset holds in_stall; the sender just waits
    check_disabled_passthrough();
    check_repeat_dropped();
    check_slot_collision();
    check_toggle_keeps_table();
    check_zero_hash();
    check_random_traffic();

    pause_for_results();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
